// ----- src/ccrc_pkg.sv -----
// ccrc_pkg: shared types, constants and CRC byte-update functions for the
// configurable CRC-32 engine. No dependencies.
`default_nettype none
package ccrc_pkg;

  localparam int CRC_W     = 32;
  localparam int BYTE_W    = 8;
  localparam int CFG_IDX_W = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_POLY      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INIT      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REFLECTED = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FINAL_XOR = 3'd3;

  // Request kinds
  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  // Reset values of the configuration registers
  localparam logic [CRC_W-1:0] POLY_RST      = 32'h04C1_1DB7;
  localparam logic [CRC_W-1:0] POLY_REV_RST  = 32'hEDB8_8320;
  localparam logic [CRC_W-1:0] INIT_RST      = 32'hFFFF_FFFF;
  localparam logic             REFLECTED_RST = 1'b1;
  localparam logic [CRC_W-1:0] FXOR_RST      = 32'hFFFF_FFFF;

  // Configuration state seen by the datapath
  typedef struct packed {
    logic [CRC_W-1:0] poly;
    logic [CRC_W-1:0] poly_rev;
    logic [CRC_W-1:0] init;
    logic             reflected;
    logic [CRC_W-1:0] fxor;
    logic             reload;
  } cfg_state_t;

  // Result request from the core to the output register
  typedef struct packed {
    logic             valid;
    logic [CRC_W-1:0] crc;
  } res_t;

  function automatic logic [CRC_W-1:0] crc_reverse(input logic [CRC_W-1:0] v);
    logic [CRC_W-1:0] r;
    for (int i = 0; i < CRC_W; i++) begin
      r[i] = v[CRC_W-1-i];
    end
    return r;
  endfunction

  // LSB-first update: fold one byte, shift right with the reversed polynomial
  function automatic logic [CRC_W-1:0] crc_step_lsb(input logic [CRC_W-1:0]  crc,
                                                    input logic [BYTE_W-1:0] b,
                                                    input logic [CRC_W-1:0]  rpoly);
    logic [CRC_W-1:0] c;
    c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
    for (int i = 0; i < BYTE_W; i++) begin
      c = c[0] ? ((c >> 1) ^ rpoly) : (c >> 1);
    end
    return c;
  endfunction

  // MSB-first update: fold one byte into the top, shift left with the polynomial
  function automatic logic [CRC_W-1:0] crc_step_msb(input logic [CRC_W-1:0]  crc,
                                                    input logic [BYTE_W-1:0] b,
                                                    input logic [CRC_W-1:0]  poly);
    logic [CRC_W-1:0] c;
    c = crc ^ {b, {(CRC_W-BYTE_W){1'b0}}};
    for (int i = 0; i < BYTE_W; i++) begin
      c = c[CRC_W-1] ? ((c << 1) ^ poly) : (c << 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ----- src/ccrc_cfg.sv -----
// ccrc_cfg: configuration registers of the CRC engine, plus the reload pulse.
// Depends on ccrc_pkg.
`default_nettype none
module ccrc_cfg (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            cfg_we,
  input  wire [ccrc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire [ccrc_pkg::CRC_W-1:0]      cfg_data,
  output ccrc_pkg::cfg_state_t           cfg_st
);
  import ccrc_pkg::*;

  logic [CRC_W-1:0] poly_r;
  logic [CRC_W-1:0] poly_rev_r;
  logic [CRC_W-1:0] init_r;
  logic             reflected_r;
  logic [CRC_W-1:0] fxor_r;
  logic             reload_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_r      <= POLY_RST;
      poly_rev_r  <= POLY_REV_RST;
      init_r      <= INIT_RST;
      reflected_r <= REFLECTED_RST;
      fxor_r      <= FXOR_RST;
      reload_r    <= 1'b0;
    end else begin
      reload_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          REG_POLY: begin
            poly_r     <= cfg_data;
            poly_rev_r <= crc_reverse(cfg_data);
            reload_r   <= 1'b1;
          end
          REG_INIT: begin
            init_r   <= cfg_data;
            reload_r <= 1'b1;
          end
          REG_REFLECTED: begin
            reflected_r <= cfg_data[0];
            reload_r    <= 1'b1;
          end
          REG_FINAL_XOR: begin
            fxor_r   <= cfg_data;
            reload_r <= 1'b1;
          end
          default: begin
            // unmapped index: ignored, no reload
          end
        endcase
      end
    end
  end

  assign cfg_st.poly      = poly_r;
  assign cfg_st.poly_rev  = poly_rev_r;
  assign cfg_st.init      = init_r;
  assign cfg_st.reflected = reflected_r;
  assign cfg_st.fxor      = fxor_r;
  assign cfg_st.reload    = reload_r;

endmodule
`default_nettype wire

// ----- src/ccrc_core.sv -----
// ccrc_core: input register, byte update logic and the CRC register.
// Depends on ccrc_pkg.
`default_nettype none
module ccrc_core (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire                          in_kind,
  input  wire [ccrc_pkg::BYTE_W-1:0]   in_data_byte,
  input  ccrc_pkg::cfg_state_t         cfg_st,
  input  wire                          res_block,
  output ccrc_pkg::res_t               res
);
  import ccrc_pkg::*;

  logic              s1_valid_r;
  logic              s1_kind_r;
  logic [BYTE_W-1:0] s1_byte_r;
  logic [CRC_W-1:0]  crc_r;
  logic [CRC_W-1:0]  crc_nxt;
  logic [CRC_W-1:0]  crc_upd;
  logic              s1_adv;

  // A finish only waits when the output register is full and stalled
  assign s1_adv   = !((s1_kind_r == KIND_FINISH) && res_block);
  assign in_stall = s1_valid_r && !s1_adv;

  always_comb begin
    if (cfg_st.reflected) begin
      crc_upd = crc_step_lsb(crc_r, s1_byte_r, cfg_st.poly_rev);
    end else begin
      crc_upd = crc_step_msb(crc_r, s1_byte_r, cfg_st.poly);
    end
  end

  always_comb begin
    crc_nxt = crc_r;
    if (cfg_st.reload) begin
      crc_nxt = cfg_st.init;
    end else if (s1_valid_r && s1_adv) begin
      crc_nxt = (s1_kind_r == KIND_FINISH) ? cfg_st.init : crc_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      crc_r      <= INIT_RST;
    end else begin
      crc_r <= crc_nxt;
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_kind_r <= in_kind;
      s1_byte_r <= in_data_byte;
    end
  end

  assign res.valid = s1_valid_r && (s1_kind_r == KIND_FINISH) && !res_block;
  assign res.crc   = crc_r ^ cfg_st.fxor;

endmodule
`default_nettype wire

// ----- src/ccrc_out.sv -----
// ccrc_out: result register that holds a CRC until the consumer takes it.
// Depends on ccrc_pkg.
`default_nettype none
module ccrc_out (
  input  wire                         clk,
  input  wire                         rst_n,
  input  ccrc_pkg::res_t              res,
  output logic                        res_block,
  output logic                        out_valid,
  input  wire                         out_stall,
  output logic [ccrc_pkg::CRC_W-1:0]  out_crc_value
);
  import ccrc_pkg::*;

  logic             out_valid_r;
  logic [CRC_W-1:0] out_crc_r;

  assign res_block = out_valid_r && out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_crc_r <= res.crc;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_crc_value = out_crc_r;

endmodule
`default_nettype wire

// ----- src/configurable_crc32_engine.sv -----
// Configurable CRC-32 engine, one byte per request, one request per cycle while in_stall is low.
// Result path: an accepted finish passes the input register, then the result register, which
//   drives out_valid.
// Stall: in_stall rises only while a finish sits in the input register and the result
//   register is full with out_stall high; data requests alone never stall the input.
// Reset (rst_n low, sync): default CRC-32 config, CRC register 0xFFFFFFFF, stages empty.
`default_nettype none
module configurable_crc32_engine (
  input  wire                            clk,
  input  wire                            rst_n,
  // request channel
  input  wire                            in_valid,
  output logic                           in_stall,
  input  wire                            in_kind,
  input  wire [ccrc_pkg::BYTE_W-1:0]     in_data_byte,
  // result channel
  output logic                           out_valid,
  input  wire                            out_stall,
  output logic [ccrc_pkg::CRC_W-1:0]     out_crc_value,
  // config write port
  input  wire                            cfg_we,
  input  wire [ccrc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire [ccrc_pkg::CRC_W-1:0]      cfg_data
);
  import ccrc_pkg::*;

  cfg_state_t cfg_st;
  res_t       res;
  logic       res_block;

  // Config registers. A write to a mapped index raises reload for one cycle,
  // which reloads the CRC register from initial_value. The reload is registered,
  // so a byte still in the input register folds in first and is then discarded
  // by the reload, as in a write after it.
  ccrc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_st    (cfg_st)
  );

  // Input register plus the byte update. Both bit orders use an eight-step
  // shift/XOR over the CRC with the byte folded in, equal to a table lookup
  // on the derived entry. The reversed polynomial is kept precomputed in
  // the config block. A data request never holds the input register; a
  // finish holds it, and so stalls whatever request waits behind it, only
  // while the result register is full and the consumer stalls.
  ccrc_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_kind      (in_kind),
    .in_data_byte (in_data_byte),
    .cfg_st       (cfg_st),
    .res_block    (res_block),
    .res          (res)
  );

  // Result register: loaded with CRC ^ final_xor when a finish leaves the
  // input register, held while out_stall is high.
  ccrc_out u_out (
    .clk           (clk),
    .rst_n         (rst_n),
    .res           (res),
    .res_block     (res_block),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_crc_value (out_crc_value)
  );

endmodule
`default_nettype wire

// ----- src/ccrc_checker.sv -----
// ccrc_checker: port-level assertions for configurable_crc32_engine, with its bind.
// Depends on ccrc_pkg.
`default_nettype none
module ccrc_checker (
  input wire                            clk,
  input wire                            rst_n,
  input wire                            in_valid,
  input wire                            in_stall,
  input wire                            in_kind,
  input wire                            out_valid,
  input wire                            out_stall,
  input wire [ccrc_pkg::CRC_W-1:0]      out_crc_value
);
  import ccrc_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_crc_value))
    else $error("result changed while stalled");

  // Requests are only held back by a full, stalled result register
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("request stalled without a stalled result");

  // A new result comes from an accepted finish request
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall && (in_kind == KIND_FINISH), 2))
    else $error("result without a finish request");

  // A data request never creates a result
  a_data_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_kind == KIND_DATA) |=> ##1 !$rose(out_valid))
    else $error("data request produced a result");

endmodule

bind configurable_crc32_engine ccrc_checker u_ccrc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .in_kind       (in_kind),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_crc_value (out_crc_value)
);
`default_nettype wire

// ----- test/tb_top.sv -----
// tb_top: self-checking bench for configurable_crc32_engine.
// Random and directed byte streams are checked against a bit-serial CRC
// predictor kept inside the bench. Depends on ccrc_pkg and the engine RTL.
module tb_top;
  import ccrc_pkg::*;

  localparam int IDLE_LIMIT = 4000;  // cycles with no handshake before giving up
  localparam int GAP_PCT    = 35;    // chance of a bubble or a stall per cycle
  localparam int NUM_REGS   = 4;
  localparam int SETTLE     = 4;     // covers the two-stage pipe before cfg writes
  localparam int PHASES     = 8;
  localparam int PHASE_REQS = 50;
  localparam logic [CFG_IDX_W-1:0] BAD_IDX_LO = CFG_IDX_W'(NUM_REGS);
  localparam logic [CFG_IDX_W-1:0] BAD_IDX_HI = '1;

  // One pending request. drain: hold it back until all CRCs are out.
  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] data_b;
    logic              drain;
  } crc_req_t;

  logic              clk          = 1'b0;
  logic              rst_n        = 1'b0;
  logic              in_valid     = 1'b0;
  logic              in_kind      = KIND_DATA;
  logic [BYTE_W-1:0] in_data_byte = '0;
  logic              in_stall;
  logic              out_valid;
  logic              out_stall    = 1'b0;
  logic [CRC_W-1:0]  out_crc_value;
  logic              cfg_we       = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_POLY;
  logic [CRC_W-1:0]  cfg_data     = '0;

  crc_req_t         req_queue[$];     // requests not yet presented
  logic [CRC_W-1:0] crc_expected[$];  // CRCs owed by the engine, oldest first

  // Predicted engine state, tracks the register file and the CRC register
  logic [CRC_W-1:0] p_poly = POLY_RST;
  logic [CRC_W-1:0] p_init = INIT_RST;
  logic             p_refl = REFLECTED_RST;
  logic [CRC_W-1:0] p_fxor = FXOR_RST;
  logic [CRC_W-1:0] p_crc  = INIT_RST;

  logic calm        = 1'b0;  // no bubbles, no stalls while set
  int   mismatches  = 0;
  int   idle_cycles = 0;
  int   sent        = 0;

  configurable_crc32_engine dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_kind      (in_kind),
    .in_data_byte (in_data_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_crc_value(out_crc_value),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Fold one byte into a CRC value, one bit at a time.
  // Reflected: low byte feeds a right shift with the mirrored polynomial.
  // Normal: top byte feeds a left shift with the polynomial as written.
  function automatic logic [CRC_W-1:0] fold_byte(input logic [CRC_W-1:0]  state,
                                                 input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] t;
    logic [CRC_W-1:0] mirror;
    for (int i = 0; i < CRC_W; i++) begin
      mirror[i] = p_poly[CRC_W-1-i];
    end
    if (p_refl) begin
      t = {{(CRC_W-BYTE_W){1'b0}}, state[BYTE_W-1:0] ^ b};
      repeat (BYTE_W) t = t[0] ? ((t >> 1) ^ mirror) : (t >> 1);
      return t ^ (state >> BYTE_W);
    end
    t = {state[CRC_W-1 -: BYTE_W] ^ b, {(CRC_W-BYTE_W){1'b0}}};
    repeat (BYTE_W) t = t[CRC_W-1] ? ((t << 1) ^ p_poly) : (t << 1);
    return t ^ (state << BYTE_W);
  endfunction

  // Accepted request: data folds in, finish owes a CRC and restarts.
  function automatic void take_request(input logic kind, input logic [BYTE_W-1:0] b);
    if (kind == KIND_FINISH) begin
      crc_expected.push_back(p_crc ^ p_fxor);
      p_crc = p_init;
    end else begin
      p_crc = fold_byte(p_crc, b);
    end
  endfunction

  // Register write: legal indexes reload the CRC register, others do nothing.
  function automatic void take_cfg(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [CRC_W-1:0]     val);
    case (idx)
      REG_POLY:      p_poly = val;
      REG_INIT:      p_init = val;
      REG_REFLECTED: p_refl = val[0];
      REG_FINAL_XOR: p_fxor = val;
      default:       return;
    endcase
    p_crc = p_init;
  endfunction

  // Request driver: payload holds while stalled; bubbles only between requests.
  always @(posedge clk) begin : drive_requests
    crc_req_t nxt;
    logic     held;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      held = in_valid && in_stall;
      if (in_valid && !in_stall) begin
        take_request(in_kind, in_data_byte);
      end
      if (!held) begin
        if (req_queue.size() > 0 && (calm || $urandom_range(99) >= GAP_PCT) &&
            !(req_queue[0].drain && crc_expected.size() > 0)) begin
          nxt          = req_queue.pop_front();
          in_valid     <= 1'b1;
          in_kind      <= nxt.kind;
          in_data_byte <= nxt.data_b;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each delivered CRC with the oldest one owed.
  always @(posedge clk) begin : check_results
    logic [CRC_W-1:0] want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (crc_expected.size() == 0) begin
          mismatches++;
          $display("%0t: crc_value with nothing owed, expected none, actual %08h",
                   $time, out_crc_value);
        end else begin
          want = crc_expected.pop_front();
          if (want !== out_crc_value) begin
            mismatches++;
            $display("%0t: crc_value mismatch, expected %08h, actual %08h",
                     $time, want, out_crc_value);
          end
        end
      end
      out_stall <= !calm && ($urandom_range(99) < GAP_PCT);
    end
  end

  // Watchdog: a long run with no handshake on either side means a hang.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic send(input logic kind, input logic [BYTE_W-1:0] b,
                      input logic drain = 1'b0);
    req_queue.push_back(crc_req_t'{kind, b, drain});
    sent++;
  endtask

  // Random message of len bytes closed by a finish; drain holds its first request.
  task automatic send_message(input int len, input logic drain);
    logic first;
    first = drain;
    repeat (len) begin
      send(KIND_DATA, BYTE_W'($urandom_range(255)), first);
      first = 1'b0;
    end
    send(KIND_FINISH, BYTE_W'($urandom_range(255)), first);
  endtask

  // Everything presented, everything delivered, pipe flushed.
  task automatic wait_idle();
    do @(posedge clk);
    while (req_queue.size() != 0 || in_valid || crc_expected.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CRC_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    take_cfg(idx, val);
  endtask

  task automatic close_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [CRC_W-1:0] pick_word();
    case ($urandom_range(3))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  initial begin : stimulus
    string            check_str;
    logic [CRC_W-1:0] w;
    int               phase_base;
    int               msg_no;
    check_str = "123456789";
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings are plain CRC-32: the classic check string first
    for (int i = 0; i < check_str.len(); i++) send(KIND_DATA, check_str[i]);
    send(KIND_FINISH, '0);
    send(KIND_FINISH, '1);           // empty message; byte on finish is ignored
    send(KIND_DATA, '0);
    send(KIND_DATA, '1);
    send(KIND_FINISH, 8'h5A);
    wait_idle();

    // MSB-first with zero init/xor; upper bits on the reflected write are dropped
    write_reg(REG_REFLECTED, 32'hFFFF_FFFE);
    write_reg(REG_INIT, '0);
    write_reg(REG_FINAL_XOR, '0);
    close_writes();
    send(KIND_DATA, '1);
    send(KIND_DATA, '0);
    send(KIND_FINISH, '0);

    // Out-of-range index mid-message must leave the CRC register alone
    send(KIND_DATA, 8'hA5);
    wait_idle();
    write_reg(BAD_IDX_LO, '1);
    write_reg(BAD_IDX_HI, $urandom);
    close_writes();
    send(KIND_FINISH, '0);

    // A legal write mid-message restarts the message
    send(KIND_DATA, 8'h3C);
    wait_idle();
    write_reg(REG_POLY, '1);
    close_writes();
    send(KIND_FINISH, '0);
    wait_idle();

    // Random phases, each with its own settings; one runs without any idling
    for (int ph = 0; ph < PHASES; ph++) begin
      calm = (ph == 3);
      write_reg(REG_POLY, ($urandom_range(3) == 0) ? POLY_RST : pick_word());
      write_reg(REG_INIT, pick_word());
      w    = $urandom;
      w[0] = ph[0];
      write_reg(REG_REFLECTED, w);
      if ($urandom_range(1)) write_reg(CFG_IDX_W'(NUM_REGS + $urandom_range(3)), $urandom);
      write_reg(REG_FINAL_XOR, pick_word());
      close_writes();

      phase_base = sent;
      msg_no     = 0;
      while (sent - phase_base < PHASE_REQS) begin
        if ($urandom_range(99) < 85) begin
          send_message(($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(12),
                       msg_no == 4);
          msg_no++;
        end else begin
          send($urandom_range(1) ? KIND_FINISH : KIND_DATA, BYTE_W'($urandom_range(255)));
        end
      end
      // Sometimes leave a message open; the next phase's writes must reload
      if ($urandom_range(1))
        repeat ($urandom_range(5, 1)) send(KIND_DATA, BYTE_W'($urandom_range(255)));
      wait_idle();
    end

    repeat (2 * SETTLE) @(posedge clk);
    if (mismatches == 0 && crc_expected.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
